@@ src/rcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rcs_pkg: shared types and constants
// Register indexes, ramp constants, sector order and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int AMP_W       = 16;
  localparam int SECTOR_W    = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_OFFSET    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_COUNT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEC_PERIOD    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_WIDTH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REFRESH_PERIOD = 3'd4;

  localparam logic [11:0] ZERO_OFFSET_RST    = 12'd0;
  localparam logic [12:0] FULL_COUNT_RST     = 13'd4096;
  localparam logic [12:0] ELEC_PERIOD_RST    = 13'd1024;
  localparam logic [10:0] SECTOR_WIDTH_RST   = 11'd170;
  localparam logic [7:0]  REFRESH_PERIOD_RST = 8'd10;

  localparam logic [AMP_W-1:0] RAMP_STEP = 16'd10;
  localparam logic [AMP_W-1:0] AMP_MAX   = 16'hFFFF;

  localparam int NUM_SECTORS = 6;

  // six-step order starting at electrical zero
  localparam logic [SECTOR_W-1:0] SECTOR_ORDER [NUM_SECTORS] = '{
    3'd5, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4
  };

  typedef struct packed {
    logic load;    // latch input word, apply offset and wrap
    logic reduce;  // one period subtraction when still above period
    logic pick;    // sector lookup
    logic commit;  // update kept state, load output register
  } rcs_cmd_t;

  typedef struct packed {
    logic reduce_done;
  } rcs_status_t;

endpackage

@@ src/rcs_in_if.sv @@
// ----------------------------------------------------------------------------
// rcs_in_if: input channel
// Valid/ready channel carrying one resolver position word and target amplitude.
// ----------------------------------------------------------------------------
interface rcs_in_if #(
  parameter int POSITION_BITS = 12
);
  logic                     valid;
  logic                     ready;
  logic [POSITION_BITS-1:0] position;
  logic [15:0]              target_amplitude;

  modport source (output valid, output position, output target_amplitude, input ready);
  modport sink   (input valid, input position, input target_amplitude, output ready);
endinterface

@@ src/rcs_out_if.sv @@
// ----------------------------------------------------------------------------
// rcs_out_if: result channel
// Valid/ready channel carrying sector, change flag and ramped amplitude.
// ----------------------------------------------------------------------------
interface rcs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  sector;
  logic        sector_changed;
  logic [15:0] amplitude;
  logic        amplitude_updated;

  modport source (output valid, output sector, output sector_changed,
                  output amplitude, output amplitude_updated, input ready);
  modport sink   (input valid, input sector, input sector_changed,
                  input amplitude, input amplitude_updated, output ready);
endinterface

@@ src/rcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcs_ctrl: sequencer
// Steps one word through load, period reduction, sector pick and commit,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module rcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rcs_pkg::rcs_cmd_t   cmd,
  input  rcs_pkg::rcs_status_t status
);
  import rcs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_PICK,
    S_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.reduce = (state == S_REDUCE);
    cmd.pick   = (state == S_PICK);
    cmd.commit = (state == S_COMMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new word replaces the one leaving in the same cycle
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (status.reduce_done) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/rcs_datapath.sv @@
// ----------------------------------------------------------------------------
// rcs_datapath: angle reduction, sector pick and amplitude ramp
// Holds the configuration registers, the working angle, the kept sector,
// refresh counter and drive amplitude, and the output register.
// ----------------------------------------------------------------------------
module rcs_datapath #(
  parameter int POSITION_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  rcs_pkg::rcs_cmd_t                   cmd,
  output rcs_pkg::rcs_status_t                status,
  input  logic [POSITION_BITS-1:0]            in_position,
  input  logic [rcs_pkg::AMP_W-1:0]           in_target,
  output logic [rcs_pkg::SECTOR_W-1:0]        out_sector,
  output logic                                out_sector_changed,
  output logic [rcs_pkg::AMP_W-1:0]           out_amplitude,
  output logic                                out_amplitude_updated
);
  import rcs_pkg::*;

  // angle may exceed the position range after the wrap by full_count
  localparam int AW = (POSITION_BITS > 13) ? POSITION_BITS : 13;
  localparam int DW = AW + 2;
  localparam int CW = (AW > 14) ? AW : 14;

  logic [11:0]          zero_offset;
  logic [12:0]          full_count;
  logic [12:0]          elec_period;
  logic [10:0]          sector_width;
  logic [7:0]           refresh_period;

  logic [AW-1:0]        angle;
  logic [AMP_W-1:0]     target;
  logic [SECTOR_W-1:0]  sector_sel;
  logic [SECTOR_W-1:0]  last_sector;
  logic [7:0]           refresh_count;
  logic [AMP_W-1:0]     drive_amplitude;

  logic [DW-1:0]        diff;
  logic [DW-1:0]        diff_wrap;
  logic [AW-1:0]        angle_load;
  logic [AW-1:0]        period_ext;
  logic [SECTOR_W-1:0]  sector_pick;
  logic                 same_sector;
  logic [7:0]           refresh_count_inc;
  logic                 ramp_due;
  logic [AMP_W-1:0]     drive_amplitude_next;
  logic                 updated_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset    <= ZERO_OFFSET_RST;
      full_count     <= FULL_COUNT_RST;
      elec_period    <= ELEC_PERIOD_RST;
      sector_width   <= SECTOR_WIDTH_RST;
      refresh_period <= REFRESH_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ZERO_OFFSET:    zero_offset    <= cfg_data[11:0];
        REG_FULL_COUNT:     full_count     <= cfg_data[12:0];
        REG_ELEC_PERIOD:    elec_period    <= cfg_data[12:0];
        REG_SECTOR_WIDTH:   sector_width   <= cfg_data[10:0];
        REG_REFRESH_PERIOD: refresh_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // offset removal, one wrap by full_count, clamp at zero
  always_comb begin
    diff       = DW'(in_position) - DW'(zero_offset);
    diff_wrap  = diff[DW-1] ? (diff + DW'(full_count)) : diff;
    angle_load = diff_wrap[DW-1] ? '0 : diff_wrap[AW-1:0];
  end

  assign period_ext         = AW'(elec_period);
  assign status.reduce_done = (elec_period == '0) || (angle <= period_ext);

  // thresholds are k * sector_width; a constant multiple per comparator
  always_comb begin
    sector_pick = SECTOR_ORDER[0];
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (CW'(angle) >= (CW'(sector_width) * CW'(k))) begin
        sector_pick = SECTOR_ORDER[k];
      end
    end
  end

  // ramp toward target on an unchanged sector
  always_comb begin
    same_sector          = (last_sector == sector_sel);
    refresh_count_inc    = refresh_count + 8'd1;
    ramp_due             = (refresh_count_inc >= refresh_period);
    drive_amplitude_next = drive_amplitude;
    updated_next         = 1'b0;
    if (same_sector && ramp_due) begin
      if (target > drive_amplitude) begin
        drive_amplitude_next = (drive_amplitude > (AMP_MAX - RAMP_STEP))
                               ? AMP_MAX : (drive_amplitude + RAMP_STEP);
        updated_next = 1'b1;
      end else if (target < drive_amplitude) begin
        drive_amplitude_next = (drive_amplitude < RAMP_STEP)
                               ? '0 : (drive_amplitude - RAMP_STEP);
        updated_next = 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle  <= angle_load;
      target <= in_target;
    end else if (cmd.reduce && !status.reduce_done) begin
      angle <= angle - period_ext;
    end
    if (cmd.pick) begin
      sector_sel <= sector_pick;
    end
  end

  // kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sector     <= '0;
      refresh_count   <= '0;
      drive_amplitude <= '0;
    end else if (cmd.commit) begin
      if (!same_sector) begin
        last_sector <= sector_sel;
      end else begin
        refresh_count   <= ramp_due ? 8'd0 : refresh_count_inc;
        drive_amplitude <= drive_amplitude_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_sector            <= sector_sel;
      out_sector_changed    <= !same_sector;
      out_amplitude         <= drive_amplitude_next;
      out_amplitude_updated <= updated_next;
    end
  end

endmodule

@@ src/resolver_commutation_sector_top.sv @@
// ----------------------------------------------------------------------------
// resolver_commutation_sector_top: six-step sector from resolver position
// Offset, period reduction, sector lookup and drive amplitude ramp.
// ----------------------------------------------------------------------------
// One word at a time. After a word is taken, the period reduction loop
// subtracts electrical_period once per cycle, n = floor((v - 1) / period)
// times when the offset-corrected angle v is above the period and 0 times
// otherwise; then come sector pick and commit, and the next word is taken
// only after commit, which waits while a stalled sink holds the result
// register. A finished result waits in the output register while the next
// word is already being worked on. The user must write the configuration
// registers through cfg_write/cfg_index/cfg_data only while the block is
// idle, which the block does not enforce. No clearing pass follows reset.
module resolver_commutation_sector_top #(
  parameter int POSITION_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  rcs_in_if.sink                          sample,
  rcs_out_if.source                       result,
  input  logic                            cfg_write,
  input  logic [rcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rcs_pkg::*;

  rcs_cmd_t    cmd;
  rcs_status_t status;

  rcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  rcs_datapath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .cmd                   (cmd),
    .status                (status),
    .in_position           (sample.position),
    .in_target             (sample.target_amplitude),
    .out_sector            (result.sector),
    .out_sector_changed    (result.sector_changed),
    .out_amplitude         (result.amplitude),
    .out_amplitude_updated (result.amplitude_updated)
  );

endmodule

@@ src/rcs_checker.sv @@
// ----------------------------------------------------------------------------
// rcs_checker: port-level checks
// Result channel behavior and result field consistency, bound to the top.
// ----------------------------------------------------------------------------
module rcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  sector,
  input logic        sector_changed,
  input logic [15:0] amplitude,
  input logic        amplitude_updated
);

  // stalled word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(sector) && $stable(sector_changed) &&
      $stable(amplitude) && $stable(amplitude_updated))
    else $error("result word changed while stalled");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sector >= 3'd1) && (sector <= 3'd6))
    else $error("sector out of range");

  // a commutation word never carries a ramp step
  a_change_no_ramp: assert property (@(posedge clk) disable iff (rst)
    out_valid && sector_changed |-> !amplitude_updated)
    else $error("ramp step on sector change");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind resolver_commutation_sector_top rcs_checker u_rcs_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (result.valid),
  .out_ready         (result.ready),
  .sector            (result.sector),
  .sector_changed    (result.sector_changed),
  .amplitude         (result.amplitude),
  .amplitude_updated (result.amplitude_updated)
);
